[src/gbt_pkg.sv]
// shared types, constants and operation codes of the tiled glyph blitter
package gbt_pkg;

  // font memory size must be a power of two so that addresses wrap by masking
  localparam int unsigned FontBytesDef   = 8192;
  localparam int unsigned TilesAcrossDef = 32;
  localparam int unsigned TileRowsDef    = 15;

  localparam int unsigned CfgW = 13;

  localparam logic [1:0] OP_FONT_WR = 2'd0;
  localparam logic [1:0] OP_DRAW    = 2'd1;
  localparam logic [1:0] OP_MEASURE = 2'd2;
  localparam logic [1:0] OP_READ    = 2'd3;

  localparam logic [7:0] SUBST_CHAR = 8'h3F;

  // font header layout
  localparam logic [17:0] HDR_HIGH_OFS  = 18'd4;
  localparam logic [17:0] HDR_TABLE_OFS = 18'd8;
  localparam logic [17:0] GLYPH_OFS     = 18'd2;

  // input item payload, first member is the most significant
  typedef struct packed {
    logic [6:0]  pad;
    logic [13:0] canvas_addr;
    logic [3:0]  color;
    logic [7:0]  pen_y;
    logic [9:0]  pen_x;
    logic [7:0]  char_code;
    logic [7:0]  font_data;
    logic [12:0] font_addr;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] glyph_width;
  } res_t;

  // canvas access request from the sequencer
  typedef struct packed {
    logic rd;      // read the byte at the request address
    logic rmw;     // merge the colour nibble and write it back next cycle
    logic nib_hi;  // odd x pixel sits in the high nibble
  } canv_ctl_t;

endpackage

[src/gbt_font_mem.sv]
// font byte memory, one write port and one registered read port
module gbt_font_mem #(
  parameter int unsigned FONT_BYTES = gbt_pkg::FontBytesDef,
  localparam int unsigned FaW = $clog2(FONT_BYTES)
) (
  input  logic           clk_i,
  input  logic           we_i,
  input  logic [FaW-1:0] waddr_i,
  input  logic [7:0]     wdata_i,
  input  logic [FaW-1:0] raddr_i,
  output logic [7:0]     rdata_o
);

  logic [7:0] mem [FONT_BYTES];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/gbt_canvas_mem.sv]
// canvas memory with nibble read-modify-write, write forwarding and reset clearing pass
module gbt_canvas_mem #(
  parameter int unsigned TILES_ACROSS = gbt_pkg::TilesAcrossDef,
  parameter int unsigned TILE_ROWS    = gbt_pkg::TileRowsDef,
  localparam int unsigned CanvasBytes = TILES_ACROSS * TILE_ROWS * 32,
  localparam int unsigned CaW = $clog2(CanvasBytes)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gbt_pkg::canv_ctl_t ctl_i,
  input  logic [CaW-1:0]    addr_i,
  input  logic [3:0]        color_i,
  output logic [7:0]        rdata_o,
  output logic              busy_o
);

  logic [7:0]     mem [CanvasBytes];
  logic [7:0]     rdata_q;

  logic           clr_busy_q;
  logic [CaW-1:0] clr_cnt_q;

  // write-back stage
  logic           b_valid_q;
  logic [CaW-1:0] b_addr_q;
  logic           b_hi_q;
  logic [3:0]     b_color_q;

  // last write, seen by a read issued in the same cycle
  logic           fwd_valid_q;
  logic [CaW-1:0] fwd_addr_q;
  logic [7:0]     fwd_data_q;

  logic [7:0]     old_byte;
  logic [7:0]     new_byte;
  logic           we;
  logic [CaW-1:0] waddr;
  logic [7:0]     wdata;

  always_comb begin
    old_byte = (fwd_valid_q && (fwd_addr_q == b_addr_q)) ? fwd_data_q : rdata_q;
    new_byte = b_hi_q ? {b_color_q, old_byte[3:0]} : {old_byte[7:4], b_color_q};
    we       = clr_busy_q || b_valid_q;
    waddr    = clr_busy_q ? clr_cnt_q : b_addr_q;
    wdata    = clr_busy_q ? 8'h00 : new_byte;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ctl_i.rd) begin
      rdata_q <= mem[addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_cnt_q   <= '0;
      b_valid_q   <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == CaW'(CanvasBytes - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      b_valid_q   <= ctl_i.rd && ctl_i.rmw;
      fwd_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_addr_q   <= addr_i;
    b_hi_q     <= ctl_i.nib_hi;
    b_color_q  <= color_i;
    fwd_addr_q <= b_addr_q;
    fwd_data_q <= new_byte;
  end

  assign rdata_o = rdata_q;
  assign busy_o  = clr_busy_q;

endmodule

[src/gbt_ctrl.sv]
// sequencer: header and offset lookup, glyph row walk, pixel requests and result register
module gbt_ctrl #(
  parameter int unsigned FONT_BYTES   = gbt_pkg::FontBytesDef,
  parameter int unsigned TILES_ACROSS = gbt_pkg::TilesAcrossDef,
  parameter int unsigned TILE_ROWS    = gbt_pkg::TileRowsDef,
  localparam int unsigned FaW         = $clog2(FONT_BYTES),
  localparam int unsigned CanvasBytes = TILES_ACROSS * TILE_ROWS * 32,
  localparam int unsigned CaW         = $clog2(CanvasBytes),
  localparam int unsigned CanvasW     = TILES_ACROSS * 8,
  localparam int unsigned CanvasH     = TILE_ROWS * 8,
  localparam int unsigned RowStride   = TILES_ACROSS * 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [gbt_pkg::CfgW-1:0] cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              in_op_i,
  input  gbt_pkg::item_t          in_item_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output gbt_pkg::res_t           out_res_o,
  output logic                    font_we_o,
  output logic [FaW-1:0]          font_waddr_o,
  output logic [7:0]              font_wdata_o,
  output logic [FaW-1:0]          font_raddr_o,
  input  logic [7:0]              font_rdata_i,
  output gbt_pkg::canv_ctl_t      canv_ctl_o,
  output logic [CaW-1:0]          canv_addr_o,
  output logic [3:0]              canv_color_o,
  input  logic [7:0]              canv_rdata_i,
  input  logic                    canv_busy_i
);

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_HI_LO  = 4'd2;
  localparam logic [3:0] ST_HI_HI  = 4'd3;
  localparam logic [3:0] ST_OFF_LO = 4'd4;
  localparam logic [3:0] ST_OFF_HI = 4'd5;
  localparam logic [3:0] ST_WID    = 4'd6;
  localparam logic [3:0] ST_HGT    = 4'd7;
  localparam logic [3:0] ST_ROWS   = 4'd8;
  localparam logic [3:0] ST_FETCH  = 4'd9;
  localparam logic [3:0] ST_BITS   = 4'd10;
  localparam logic [3:0] ST_PIX    = 4'd11;
  localparam logic [3:0] ST_FIN    = 4'd12;

  logic [3:0]               state_q, state_d;
  logic [gbt_pkg::CfgW-1:0] font_base_q;

  logic [1:0]     op_q;
  logic [7:0]     ch_q;
  logic [9:0]     px_q;
  logic [7:0]     py_q;
  logic [3:0]     color_q;
  logic           rd_ok_q;

  logic [7:0]     lo_q, lo_d;
  logic [FaW-1:0] addr_q, addr_d;
  logic [FaW-1:0] p_q, p_d;
  logic [7:0]     width_q, width_d;
  logic [7:0]     height_q, height_d;
  logic [7:0]     col_q, col_d;
  logic [7:0]     row_q, row_d;
  logic [7:0]     bits_q, bits_d;

  logic           out_valid_q;
  gbt_pkg::res_t  res_q;

  logic           accept;
  logic [15:0]    high16;
  logic [7:0]     chsel;
  logic [17:0]    hi_addr;
  logic [17:0]    tab_addr;
  logic [17:0]    glyph_addr;
  logic [10:0]    pix_x;
  logic [8:0]     pix_y;
  logic           in_canvas;
  logic [19:0]    pix_idx;
  logic [7:0]     col_n;
  logic           can_finish;
  logic           in_rd_ok;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE) && !canv_busy_i;
  assign can_finish = !out_valid_q || out_ready_i;
  assign in_rd_ok   = 32'(in_item_i.canvas_addr) < CanvasBytes;

  always_comb begin
    high16     = {font_rdata_i, lo_q};
    chsel      = (16'(ch_q) >= high16) ? gbt_pkg::SUBST_CHAR : ch_q;
    hi_addr    = 18'(font_base_q) + gbt_pkg::HDR_HIGH_OFS;
    tab_addr   = 18'(font_base_q) + gbt_pkg::HDR_TABLE_OFS + {9'd0, chsel, 1'b0};
    glyph_addr = 18'(font_base_q) + gbt_pkg::GLYPH_OFS + 18'({font_rdata_i, lo_q});
    pix_x      = 11'(px_q) + 11'(col_q);
    pix_y      = 9'(py_q) + 9'(row_q);
    in_canvas  = (pix_x < 11'(CanvasW)) && (pix_y < 9'(CanvasH));
    pix_idx    = 20'(pix_x[10:3]) * 20'd32 + 20'(pix_y[8:3]) * 20'(RowStride)
               + 20'({pix_y[2:0], 2'b00}) + 20'(pix_x[2:1]);
    col_n      = col_q + 8'd1;
  end

  // font read address per step
  always_comb begin
    case (state_q)
      ST_HI_LO:  font_raddr_o = hi_addr[FaW-1:0];
      ST_HI_HI:  font_raddr_o = hi_addr[FaW-1:0] + FaW'(1);
      ST_OFF_LO: font_raddr_o = tab_addr[FaW-1:0];
      ST_OFF_HI: font_raddr_o = addr_q + FaW'(1);
      ST_WID:    font_raddr_o = glyph_addr[FaW-1:0];
      ST_HGT:    font_raddr_o = addr_q + FaW'(1);
      ST_FETCH:  font_raddr_o = p_q;
      default:   font_raddr_o = addr_q;
    endcase
  end

  always_comb begin
    font_we_o    = accept && (in_op_i == gbt_pkg::OP_FONT_WR);
    font_waddr_o = FaW'(in_item_i.font_addr);
    font_wdata_o = in_item_i.font_data;

    canv_ctl_o   = '0;
    canv_addr_o  = pix_idx[CaW-1:0];
    canv_color_o = color_q;
    if (state_q == ST_PIX) begin
      canv_ctl_o.rd     = bits_q[7] && in_canvas;
      canv_ctl_o.rmw    = 1'b1;
      canv_ctl_o.nib_hi = pix_x[0];
    end else if (accept && (in_op_i == gbt_pkg::OP_READ)) begin
      canv_ctl_o.rd = in_rd_ok;
      canv_addr_o   = CaW'(in_item_i.canvas_addr);
    end
  end

  always_comb begin
    state_d  = state_q;
    lo_d     = lo_q;
    addr_d   = addr_q;
    p_d      = p_q;
    width_d  = width_q;
    height_d = height_q;
    col_d    = col_q;
    row_d    = row_q;
    bits_d   = bits_q;
    case (state_q)
      ST_CLEAR: begin
        if (!canv_busy_i) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          width_d = 8'd0;
          if ((in_op_i == gbt_pkg::OP_DRAW) || (in_op_i == gbt_pkg::OP_MEASURE)) begin
            state_d = ST_HI_LO;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_HI_LO:  state_d = ST_HI_HI;
      ST_HI_HI: begin
        lo_d    = font_rdata_i;
        state_d = ST_OFF_LO;
      end
      ST_OFF_LO: begin
        addr_d  = tab_addr[FaW-1:0];
        state_d = ST_OFF_HI;
      end
      ST_OFF_HI: begin
        lo_d    = font_rdata_i;
        state_d = ST_WID;
      end
      ST_WID: begin
        addr_d  = glyph_addr[FaW-1:0];
        state_d = ST_HGT;
      end
      ST_HGT: begin
        width_d = font_rdata_i;
        state_d = (op_q == gbt_pkg::OP_DRAW) ? ST_ROWS : ST_FIN;
      end
      ST_ROWS: begin
        height_d = font_rdata_i;
        p_d      = addr_q + FaW'(2);
        col_d    = 8'd0;
        row_d    = 8'd0;
        state_d  = ((width_q == 8'd0) || (font_rdata_i == 8'd0)) ? ST_FIN : ST_FETCH;
      end
      ST_FETCH: begin
        p_d     = p_q + FaW'(1);
        state_d = ST_BITS;
      end
      ST_BITS: begin
        bits_d  = font_rdata_i;
        state_d = ST_PIX;
      end
      ST_PIX: begin
        bits_d = {bits_q[6:0], 1'b0};
        if (col_n == width_q) begin
          col_d = 8'd0;
          if (row_q + 8'd1 == height_q) begin
            state_d = ST_FIN;
          end else begin
            row_d   = row_q + 8'd1;
            state_d = ST_FETCH;
          end
        end else begin
          col_d = col_n;
          if (col_n[2:0] == 3'd0) begin
            state_d = ST_FETCH;
          end
        end
      end
      ST_FIN: begin
        if (can_finish) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      font_base_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        font_base_q <= cfg_wdata_i;
      end
      if ((state_q == ST_FIN) && can_finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q     <= lo_d;
    addr_q   <= addr_d;
    p_q      <= p_d;
    width_q  <= width_d;
    height_q <= height_d;
    col_q    <= col_d;
    row_q    <= row_d;
    bits_q   <= bits_d;
    if (accept) begin
      op_q    <= in_op_i;
      ch_q    <= in_item_i.char_code;
      px_q    <= in_item_i.pen_x;
      py_q    <= in_item_i.pen_y;
      color_q <= in_item_i.color;
      rd_ok_q <= in_rd_ok;
    end
    if ((state_q == ST_FIN) && can_finish) begin
      res_q.glyph_width <= width_q;
      res_q.read_data   <= ((op_q == gbt_pkg::OP_READ) && rd_ok_q) ? canv_rdata_i : 8'd0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

  a_no_accept_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    canv_busy_i |-> !in_ready_o) else $error("item accepted during canvas clear");

  a_accept_leaves_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != ST_IDLE)) else $error("sequencer stayed idle after accept");

  a_rmw_only_in_pixel : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (canv_ctl_o.rd && canv_ctl_o.rmw) |-> (state_q == ST_PIX))
    else $error("canvas write-back outside pixel walk");

  a_result_from_fin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FIN))
    else $error("result loaded outside finish step");

endmodule

[src/glyph_blitter_tiled_4bpp.sv]
// top level of the tiled 4bpp glyph blitter: stream ports, font and canvas memories, sequencer
//
// After reset the canvas is cleared one byte per cycle, TILES_ACROSS*TILE_ROWS*32 bytes
// (15360 at the defaults), and no item is taken until that pass ends; font_base writes are
// taken at any time. Items are handled one at a time. A font byte write or a canvas byte read
// goes straight to the finish step; a measure reads the high character, offset and width.
// A draw also reads the height; each set canvas pixel is a read-modify-write on the canvas
// memory port, one per cycle between glyph byte fetches, and each glyph byte takes a fetch and
// a bits step on the font read port. A finished result sits in an output register, and the
// next item is taken while it waits to be read out. FONT_BYTES must be a power of two.
module glyph_blitter_tiled_4bpp #(
  parameter int unsigned FONT_BYTES   = gbt_pkg::FontBytesDef,
  parameter int unsigned TILES_ACROSS = gbt_pkg::TilesAcrossDef,
  parameter int unsigned TILE_ROWS    = gbt_pkg::TileRowsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [gbt_pkg::CfgW-1:0] cfg_wdata_i,  // font_base
  input  logic                     s_tvalid_i,
  output logic                     s_tready_o,
  // font_addr, font_data, char_code, pen_x, pen_y, color, canvas_addr
  input  logic [71:0]              s_tdata_i,
  input  logic [1:0]               s_tuser_i,    // op
  output logic                     m_tvalid_o,
  input  logic                     m_tready_i,
  output logic [15:0]              m_tdata_o     // glyph_width, read_data
);

  localparam int unsigned FaW         = $clog2(FONT_BYTES);
  localparam int unsigned CanvasBytes = TILES_ACROSS * TILE_ROWS * 32;
  localparam int unsigned CaW         = $clog2(CanvasBytes);

  gbt_pkg::item_t     item;
  gbt_pkg::res_t      res;
  gbt_pkg::canv_ctl_t canv_ctl;

  logic           font_we;
  logic [FaW-1:0] font_waddr;
  logic [7:0]     font_wdata;
  logic [FaW-1:0] font_raddr;
  logic [7:0]     font_rdata;
  logic [CaW-1:0] canv_addr;
  logic [3:0]     canv_color;
  logic [7:0]     canv_rdata;
  logic           canv_busy;

  assign item      = gbt_pkg::item_t'(s_tdata_i);
  assign m_tdata_o = res;

  gbt_font_mem #(
    .FONT_BYTES (FONT_BYTES)
  ) u_font (
    .clk_i   (clk_i),
    .we_i    (font_we),
    .waddr_i (font_waddr),
    .wdata_i (font_wdata),
    .raddr_i (font_raddr),
    .rdata_o (font_rdata)
  );

  gbt_canvas_mem #(
    .TILES_ACROSS (TILES_ACROSS),
    .TILE_ROWS    (TILE_ROWS)
  ) u_canvas (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (canv_ctl),
    .addr_i  (canv_addr),
    .color_i (canv_color),
    .rdata_o (canv_rdata),
    .busy_o  (canv_busy)
  );

  gbt_ctrl #(
    .FONT_BYTES   (FONT_BYTES),
    .TILES_ACROSS (TILES_ACROSS),
    .TILE_ROWS    (TILE_ROWS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (s_tvalid_i),
    .in_ready_o   (s_tready_o),
    .in_op_i      (s_tuser_i),
    .in_item_i    (item),
    .out_valid_o  (m_tvalid_o),
    .out_ready_i  (m_tready_i),
    .out_res_o    (res),
    .font_we_o    (font_we),
    .font_waddr_o (font_waddr),
    .font_wdata_o (font_wdata),
    .font_raddr_o (font_raddr),
    .font_rdata_i (font_rdata),
    .canv_ctl_o   (canv_ctl),
    .canv_addr_o  (canv_addr),
    .canv_color_o (canv_color),
    .canv_rdata_i (canv_rdata),
    .canv_busy_i  (canv_busy)
  );

endmodule

[tb/tb_glyph_blitter_tiled_4bpp.sv]
// self-checking testbench for the tiled 4bpp glyph blitter: loads fonts, draws, measures, reads back
module tb_glyph_blitter_tiled_4bpp;
  import gbt_pkg::*;

  localparam int unsigned FontBytes   = FontBytesDef;
  localparam int unsigned CanvasW     = TilesAcrossDef * 8;
  localparam int unsigned CanvasH     = TileRowsDef * 8;
  localparam int unsigned RowStride   = TilesAcrossDef * 32;
  localparam int unsigned CanvasBytes = TilesAcrossDef * TileRowsDef * 32;
  // glyph records go after the header and a full 256-entry offset table
  localparam int unsigned GlyphAreaOfs = 520;
  localparam int unsigned Limit        = 2_000_000;

  class blit_scoreboard;
    logic [7:0]  font_img [FontBytes];
    bit          font_valid [FontBytes];
    logic [7:0]  canvas_img [CanvasBytes];
    logic [12:0] font_base;
    res_t        owed_results [$];
    int unsigned touched_q [$];
    int unsigned errors;

    function new();
      foreach (canvas_img[i]) canvas_img[i] = '0;
      foreach (font_valid[i]) font_valid[i] = 1'b0;
      font_base = '0;
      errors = 0;
    endfunction

    function logic [15:0] font_word(logic [12:0] a);
      return {font_img[a + 13'd1], font_img[a]};
    endfunction

    // offset table entry used for ch, after the high-character substitution
    function logic [12:0] entry_at(logic [7:0] ch);
      logic [7:0] c;
      c = (16'(ch) >= font_word(font_base + 13'd4)) ? SUBST_CHAR : ch;
      return font_base + 13'd8 + {4'd0, c, 1'b0};
    endfunction

    function logic [12:0] glyph_at(logic [7:0] ch);
      logic [15:0] ofs;
      ofs = font_word(entry_at(ch));
      return font_base + 13'd2 + ofs[12:0];
    endfunction

    // true when every font byte the operation would read has been written
    function bit readable(logic [1:0] op, logic [7:0] ch);
      logic [12:0] ep, g;
      int unsigned n, i;
      if (!font_valid[font_base + 13'd4] || !font_valid[font_base + 13'd5]) return 1'b0;
      ep = entry_at(ch);
      if (!font_valid[ep] || !font_valid[ep + 13'd1]) return 1'b0;
      g = glyph_at(ch);
      if (!font_valid[g]) return 1'b0;
      if (op != OP_DRAW) return 1'b1;
      if (!font_valid[g + 13'd1]) return 1'b0;
      n = int'(font_img[g + 13'd1]) * ((int'(font_img[g]) + 7) / 8);
      for (i = 0; i < n; i++)
        if (!font_valid[g + 13'd2 + 13'(i)]) return 1'b0;
      return 1'b1;
    endfunction

    function void plot(int unsigned x, int unsigned y, logic [3:0] c);
      int unsigned idx;
      if (x >= CanvasW || y >= CanvasH) return;
      idx = (x / 8) * 32 + (y / 8) * RowStride + (y % 8) * 4 + (x % 8) / 2;
      if (x[0]) canvas_img[idx][7:4] = c;
      else canvas_img[idx][3:0] = c;
      touched_q.push_back(idx);
      if (touched_q.size() > 256) void'(touched_q.pop_front());
    endfunction

    function void predict_result(logic [1:0] op, item_t it);
      res_t        r;
      logic [12:0] g, p;
      logic [7:0]  w, h, bits;
      int unsigned row, col;
      r = '0;
      case (op)
        OP_FONT_WR: begin
          font_img[it.font_addr] = it.font_data;
          font_valid[it.font_addr] = 1'b1;
        end
        OP_DRAW, OP_MEASURE: begin
          g = glyph_at(it.char_code);
          w = font_img[g];
          r.glyph_width = w;
          if (op == OP_DRAW) begin
            h = font_img[g + 13'd1];
            p = g + 13'd2;
            bits = '0;
            for (row = 0; row < h; row++) begin
              for (col = 0; col < w; col++) begin
                // each row starts on a fresh byte, msb first
                if (col % 8 == 0) begin
                  bits = font_img[p];
                  p = p + 13'd1;
                end
                if (bits[7]) plot(int'(it.pen_x) + col, int'(it.pen_y) + row, it.color);
                bits = bits << 1;
              end
            end
          end
        end
        OP_READ: begin
          if (it.canvas_addr < CanvasBytes) r.read_data = canvas_img[it.canvas_addr];
        end
      endcase
      owed_results.push_back(r);
    endfunction

    task report(string what);
      errors++;
      $display("mismatch at %0t: %s", $time, what);
    endtask

    task check_result(res_t got);
      res_t want;
      if (owed_results.size() == 0) begin
        report($sformatf("result %h with nothing outstanding", got));
        return;
      end
      want = owed_results.pop_front();
      if (got.glyph_width !== want.glyph_width)
        report($sformatf("glyph_width %h, predicted %h", got.glyph_width, want.glyph_width));
      if (got.read_data !== want.read_data)
        report($sformatf("read_data %h, predicted %h", got.read_data, want.read_data));
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgW-1:0]     cfg_wdata_i = '0;
  logic                s_tvalid_i  = 1'b0;
  logic                s_tready_o;
  // font_addr, font_data, char_code, pen_x, pen_y, color, canvas_addr
  item_t               s_tdata_i   = '0;
  logic [1:0]          s_tuser_i   = OP_FONT_WR;  // op
  logic                m_tvalid_o;
  logic                m_tready_i  = 1'b0;
  res_t                m_tdata_o;  // glyph_width, read_data

  blit_scoreboard sb = new();
  bit             no_idle = 1'b0;
  int unsigned    cycles = 0;
  logic [12:0]    cur_base = '0;
  logic [12:0]    glyph_cursor = '0;
  logic [7:0]     font_chars [$];

  glyph_blitter_tiled_4bpp uut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .s_tvalid_i,
    .s_tready_o,
    .s_tdata_i,
    .s_tuser_i,
    .m_tvalid_o,
    .m_tready_i,
    .m_tdata_o
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= Limit) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (m_tvalid_o && m_tready_i) sb.check_result(m_tdata_o);
    m_tready_i <= no_idle || ($urandom_range(0, 99) >= 15);
  end

  // fields the operation does not use carry random bits
  function automatic item_t rand_item();
    item_t it;
    it = 72'({$urandom, $urandom, $urandom});
    it.pad = '0;
    return it;
  endfunction

  function automatic logic [7:0] glyph_dim(int unsigned usual, int unsigned most);
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(usual + 1, most));
    return 8'($urandom_range(0, usual));
  endfunction

  task automatic send_item(input logic [1:0] op, input item_t it);
    while (!no_idle && $urandom_range(0, 99) < 15) begin
      s_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= op;
    s_tdata_i  <= it;
    do @(posedge clk_i); while (!s_tready_o);
    sb.predict_result(op, it);
  endtask

  task automatic font_byte(input logic [12:0] a, input logic [7:0] d);
    item_t it;
    it = rand_item();
    it.font_addr = a;
    it.font_data = d;
    send_item(OP_FONT_WR, it);
  endtask

  task automatic glyph_op(input logic [1:0] op, input logic [7:0] ch, input logic [9:0] x,
                          input logic [7:0] y, input logic [3:0] c);
    item_t it;
    it = rand_item();
    it.char_code = ch;
    it.pen_x = x;
    it.pen_y = y;
    it.color = c;
    send_item(op, it);
  endtask

  task automatic read_byte(input logic [13:0] a);
    item_t it;
    it = rand_item();
    it.canvas_addr = a;
    send_item(OP_READ, it);
  endtask

  task automatic wait_results();
    s_tvalid_i <= 1'b0;
    while (sb.owed_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_font_base(input logic [12:0] b);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= b;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.font_base = b;
    cur_base = b;
  endtask

  task automatic add_glyph(input logic [7:0] ch, input logic [7:0] w, input logic [7:0] h);
    logic [12:0] ep, g;
    logic [15:0] ofs;
    int unsigned i, nb;
    g = glyph_cursor;
    ep = cur_base + 13'd8 + {4'd0, ch, 1'b0};
    // the top offset bits drop out when the address wraps, so they are random
    ofs = {3'($urandom), 13'(g - cur_base - 13'd2)};
    font_byte(ep, ofs[7:0]);
    font_byte(ep + 13'd1, ofs[15:8]);
    font_byte(g, w);
    font_byte(g + 13'd1, h);
    nb = int'(h) * ((int'(w) + 7) / 8);
    for (i = 0; i < nb; i++) font_byte(g + 13'd2 + 13'(i), 8'($urandom));
    glyph_cursor = g + 13'd2 + 13'(nb);
    font_chars.push_back(ch);
  endtask

  task automatic build_font(input logic [15:0] high, input int unsigned n);
    logic [7:0] ch;
    glyph_cursor = cur_base + 13'(GlyphAreaOfs);
    font_chars.delete();
    font_byte(cur_base + 13'd4, high[7:0]);
    font_byte(cur_base + 13'd5, high[15:8]);
    add_glyph(SUBST_CHAR, glyph_dim(16, 24), glyph_dim(12, 16));
    repeat (n) begin
      if (high != 0 && $urandom_range(0, 9) < 7)
        ch = 8'($urandom_range(0, (high > 256) ? 255 : int'(high) - 1));
      else
        ch = 8'($urandom);
      add_glyph(ch, glyph_dim(16, 24), glyph_dim(12, 16));
    end
  endtask

  task automatic random_ops(input int unsigned n);
    int unsigned sel, k, span;
    logic [7:0]  ch;
    logic [1:0]  op;
    logic [9:0]  x;
    logic [7:0]  y;
    bit          ok;
    repeat (n) begin
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        op = (sel < 40) ? OP_DRAW : OP_MEASURE;
        if (font_chars.size() != 0 && $urandom_range(0, 1) == 1)
          ch = font_chars[$urandom_range(0, font_chars.size() - 1)];
        else
          ch = 8'($urandom);
        ok = sb.readable(op, ch);
        // fall back to a glyph whose bytes are all loaded
        for (k = 0; k < font_chars.size() && !ok; k++) begin
          ch = font_chars[k];
          ok = sb.readable(op, ch);
        end
        if ($urandom_range(0, 9) == 0) begin
          x = 10'($urandom);
          y = 8'($urandom);
        end else begin
          x = 10'($urandom_range(0, CanvasW - 4));
          y = 8'($urandom_range(0, CanvasH - 4));
        end
        if (ok) glyph_op(op, ch, x, y, 4'($urandom));
        else read_byte(14'($urandom_range(0, CanvasBytes - 1)));
      end else if (sel < 88) begin
        k = $urandom_range(0, 9);
        if (k < 6 && sb.touched_q.size() != 0)
          read_byte(14'(sb.touched_q[$urandom_range(0, sb.touched_q.size() - 1)]));
        else if (k < 9)
          read_byte(14'($urandom_range(0, CanvasBytes - 1)));
        else
          read_byte(14'($urandom_range(CanvasBytes, 16383)));
      end else begin
        // font overwrites, half of them inside the current glyph records
        span = 32'(13'(glyph_cursor - cur_base - 13'(GlyphAreaOfs)));
        if ($urandom_range(0, 1) == 1)
          font_byte(cur_base + 13'(GlyphAreaOfs) + 13'($urandom_range(0, span)), 8'($urandom));
        else
          font_byte(13'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    int unsigned ph;
    logic [12:0] b;
    logic [15:0] high;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_font_base(13'd0);

    read_byte(14'd0);
    build_font(16'h0041, 0);
    add_glyph(8'h40, 8'd12, 8'd3);
    add_glyph(8'h00, 8'd0, 8'd3);
    add_glyph(8'h01, 8'd255, 8'd1);
    add_glyph(8'h02, 8'd1, 8'd255);
    add_glyph(8'h03, 8'd16, 8'd0);
    glyph_op(OP_DRAW, SUBST_CHAR, 10'd0, 8'd0, 4'hF);
    glyph_op(OP_DRAW, 8'h40, 10'd250, 8'd117, 4'hA);   // clipped right
    glyph_op(OP_DRAW, 8'h01, 10'd0, 8'd119, 4'h5);     // widest glyph on the last row
    glyph_op(OP_DRAW, 8'h02, 10'd255, 8'd0, 4'h0);     // tallest glyph in the last column
    glyph_op(OP_DRAW, 8'h00, 10'd10, 8'd10, 4'h7);
    glyph_op(OP_DRAW, 8'h03, 10'd20, 8'd20, 4'h3);
    glyph_op(OP_MEASURE, 8'h40, 10'd0, 8'd0, 4'h0);
    glyph_op(OP_MEASURE, 8'hFF, 10'd0, 8'd0, 4'h0);    // above high, becomes '?'
    glyph_op(OP_DRAW, 8'hFF, 10'd1023, 8'd255, 4'hF);  // entirely off the canvas
    glyph_op(OP_DRAW, 8'h41, 10'd248, 8'd112, 4'h3);   // exactly the high character
    read_byte(14'd0);
    read_byte(14'd1);
    read_byte(14'd4);
    read_byte(14'(CanvasBytes - 1));
    read_byte(14'(CanvasBytes));
    read_byte(14'h3FFF);
    // lower the high character below '?' itself
    font_byte(cur_base + 13'd4, 8'h20);
    glyph_op(OP_DRAW, 8'h30, 10'd100, 8'd50, 4'h9);
    glyph_op(OP_MEASURE, 8'h00, 10'd0, 8'd0, 4'h0);
    font_byte(13'h1FFF, 8'hFF);

    random_ops(80);
    for (ph = 1; ph <= 4; ph++) begin
      wait_results();
      case (ph)
        1: begin
          b = 13'h1FFF;
          high = 16'($urandom_range(1, 63));
        end
        2: begin
          b = 13'($urandom);
          high = 16'($urandom_range(64, 255));
        end
        3: begin
          b = 13'h1000;
          high = 16'($urandom_range(256, 65535));
        end
        default: begin
          b = 13'($urandom);
          high = 16'd0;
        end
      endcase
      no_idle = (ph == 2);
      write_font_base(b);
      build_font(high, $urandom_range(3, 6));
      random_ops(80);
    end
    no_idle = 1'b0;

    wait_results();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
